@@ hdl/rgbkf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbkf_pkg
// Shared types, register indexes and constants of the RGB 3x3 kernel filter.
// ----------------------------------------------------------------------------
package rgbkf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_RESET   = 1024;
  localparam int HEIGHT_LIMIT  = 4096;

  localparam int ROW_W      = 13;
  localparam int MODE_W     = 3;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd4;

  localparam logic [ROW_W-1:0] HEIGHT_RESET = 13'd1024;
  localparam logic [ROW_W-1:0] HEIGHT_MAX   = 13'd4096;

  // floor(x / 9) == (x * BOX_RECIP) >> BOX_SHIFT for x below 4096
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int          BOX_SHIFT = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic       filler;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic up_ok;
    logic down_ok;
    logic last;
  } win_ctl_t;

  typedef struct packed {
    pix_t top;
    pix_t mid;
  } line_entry_t;

  // window[col][row], col 2 is the newest column, row 2 the current row
  typedef pix_t    [2:0] win_col_t;
  typedef win_col_t [2:0] window_t;

endpackage

@@ hdl/rgb_3x3_kernel_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_3x3_kernel_filter
// Streaming 3x3 convolution (box, Gaussian, outline, emboss, sharpen) of an
// RGB frame in raster order, edge neighbors skipped, results clamped to 0..255.
//
// Input beats carry one pixel on in_data (valid/ready). Once a frame's pixels
// are in, in_data.filler beats (or any beat) drain the remaining results;
// filler beats before that are taken and dropped. Results leave on out_data
// (valid/ready); frame_end marks the last pixel of the frame.
// A beat is taken every cycle while the result side keeps up: one pixel per
// clock. The result caused by a beat is held in the window stage and then in
// the output register; it is one row plus one pixel behind the stream. The
// line buffer is a single memory port pair read ahead at the next column.
// When out_ready is low, one result waits in the output register and one in
// the window stage; in_ready then drops until the output register frees.
// cfg_we writes a register (0 kernel_mode, 1 frame_width, 2 frame_height);
// a size write restarts the frame. Write only while the block is idle.
// Reset (rst_n low, synchronous) gives box blur, 1024x1024, empty pipeline.
// ----------------------------------------------------------------------------
module rgb_3x3_kernel_filter #(
  parameter int MAX_WIDTH = rgbkf_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rgbkf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbkf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rgbkf_pkg::in_item_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rgbkf_pkg::out_item_t             out_data
);

  logic                s1_valid;
  logic                out_free;
  logic                take;
  rgbkf_pkg::window_t  win;
  rgbkf_pkg::win_ctl_t ctl;

  assign in_ready = !s1_valid || out_free;
  assign take     = in_valid && in_ready;

  rgbkf_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_data   (in_data),
    .adv       (out_free),
    .s1_valid  (s1_valid),
    .win       (win),
    .ctl       (ctl)
  );

  rgbkf_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s1_valid  (s1_valid),
    .win       (win),
    .ctl       (ctl),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_free  (out_free)
  );

endmodule

@@ hdl/rgbkf_line_store.sv @@
// ----------------------------------------------------------------------------
// rgbkf_line_store
// Two-row line buffer: one entry per column holds the pixels of the two
// previous rows. Registered read with write-to-read bypass.
// ----------------------------------------------------------------------------
module rgbkf_line_store #(
  parameter int MAX_WIDTH = rgbkf_pkg::MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                   wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  rgbkf_pkg::line_entry_t wr_data,
  output rgbkf_pkg::line_entry_t rd_data
);

  rgbkf_pkg::line_entry_t mem [MAX_WIDTH];
  rgbkf_pkg::line_entry_t rd_data_r;
  rgbkf_pkg::line_entry_t byp_data_r;
  logic                   byp_r;

  always_ff @(posedge clk) begin
    rd_data_r  <= mem[rd_addr];
    byp_data_r <= wr_data;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_data_r;

endmodule

@@ hdl/rgbkf_window.sv @@
// ----------------------------------------------------------------------------
// rgbkf_window
// Frame position tracking, line buffer access and the 3x3 pixel window.
// Holds the window and its edge flags as the input stage of the filter.
// ----------------------------------------------------------------------------
module rgbkf_window #(
  parameter int MAX_WIDTH = rgbkf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgbkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbkf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                take,
  input  rgbkf_pkg::in_item_t                 in_data,
  input  logic                                adv,
  output logic                                s1_valid,
  output rgbkf_pkg::window_t                  win,
  output rgbkf_pkg::win_ctl_t                 ctl
);

  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int W_RESET_LAST =
    ((MAX_WIDTH < rgbkf_pkg::WIDTH_RESET) ? MAX_WIDTH : rgbkf_pkg::WIDTH_RESET) - 1;
  localparam int ROW_W        = rgbkf_pkg::ROW_W;

  logic [COL_W-1:0]       col_r, col_nxt;
  logic [COL_W-1:0]       w_last_r, w_last_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ROW_W-1:0]       h_r, h_nxt;
  rgbkf_pkg::window_t     win_r, win_nxt;
  rgbkf_pkg::win_ctl_t    ctl_r, ctl_nxt;
  logic                   s1_v_r, s1_v_nxt;

  rgbkf_pkg::line_entry_t rd_entry;
  rgbkf_pkg::line_entry_t wr_entry;
  rgbkf_pkg::pix_t        pix;
  logic [rgbkf_pkg::FW_W-1:0] fw_raw;
  logic [rgbkf_pkg::FH_W-1:0] fh_raw;
  logic                   size_we;
  logic                   draining;
  logic                   act;
  logic                   col_zero;
  logic                   emit;

  rgbkf_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (col_nxt),
    .wr_en   (act),
    .wr_addr (col_r),
    .wr_data (wr_entry),
    .rd_data (rd_entry)
  );

  // frame size registers, clamped at write
  always_comb begin
    fw_raw     = cfg_data[rgbkf_pkg::FW_W-1:0];
    fh_raw     = cfg_data[rgbkf_pkg::FH_W-1:0];
    size_we    = cfg_we && ((cfg_index == rgbkf_pkg::REG_FRAME_WIDTH) ||
                            (cfg_index == rgbkf_pkg::REG_FRAME_HEIGHT));
    w_last_nxt = w_last_r;
    h_nxt      = h_r;
    if (cfg_we && (cfg_index == rgbkf_pkg::REG_FRAME_WIDTH)) begin
      if (fw_raw == '0) begin
        w_last_nxt = '0;
      end else if (32'(fw_raw) > 32'(MAX_WIDTH)) begin
        w_last_nxt = COL_W'(MAX_WIDTH - 1);
      end else begin
        w_last_nxt = COL_W'(fw_raw - 1'b1);
      end
    end
    if (cfg_we && (cfg_index == rgbkf_pkg::REG_FRAME_HEIGHT)) begin
      if (fh_raw == '0) begin
        h_nxt = ROW_W'(1);
      end else if (fh_raw > rgbkf_pkg::HEIGHT_MAX) begin
        h_nxt = rgbkf_pkg::HEIGHT_MAX;
      end else begin
        h_nxt = fh_raw;
      end
    end
  end

  always_comb begin
    draining  = row_r >= h_r;
    act       = take && (draining || !in_data.filler);
    pix.red   = draining ? 8'd0 : in_data.in_red;
    pix.green = draining ? 8'd0 : in_data.in_green;
    pix.blue  = draining ? 8'd0 : in_data.in_blue;
    col_zero  = col_r == '0;
    emit      = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && !col_zero);

    ctl_nxt.left_ok  = col_zero ? (w_last_r != '0) : (col_r >= COL_W'(2));
    ctl_nxt.right_ok = !col_zero;
    ctl_nxt.up_ok    = col_zero ? (row_r >= ROW_W'(3)) : (row_r >= ROW_W'(2));
    ctl_nxt.down_ok  = col_zero ? (row_r <= h_r) : (row_r < h_r);
    ctl_nxt.last     = col_zero && (row_r == (h_r + ROW_W'(1)));

    wr_entry.top = rd_entry.mid;
    wr_entry.mid = pix;

    col_nxt = col_r;
    row_nxt = row_r;
    if (size_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (act) begin
      if (emit && ctl_nxt.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_last_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    win_nxt = win_r;
    if (act) begin
      win_nxt[0]    = win_r[1];
      win_nxt[1]    = win_r[2];
      win_nxt[2][0] = rd_entry.top;
      win_nxt[2][1] = rd_entry.mid;
      win_nxt[2][2] = pix;
    end

    if (act) begin
      s1_v_nxt = emit;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      w_last_r <= COL_W'(W_RESET_LAST);
      h_r      <= rgbkf_pkg::HEIGHT_RESET;
      s1_v_r   <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      w_last_r <= w_last_nxt;
      h_r      <= h_nxt;
      s1_v_r   <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (act) begin
      ctl_r <= ctl_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign win      = win_r;
  assign ctl      = ctl_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= w_last_r)
    else $error("column position beyond frame width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= (h_r + ROW_W'(1)))
    else $error("row position beyond drain limit");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (!s1_v_r || adv))
    else $error("window shifted while stage result not taken");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(ctl_r) && (win_r === $past(win_r))))
    else $error("stalled stage changed");

endmodule

@@ hdl/rgbkf_conv.sv @@
// ----------------------------------------------------------------------------
// rgbkf_conv
// Kernel arithmetic on the masked window for all three channels, scaling,
// clamping and the result register.
// ----------------------------------------------------------------------------
module rgbkf_conv (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rgbkf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbkf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             s1_valid,
  input  rgbkf_pkg::window_t               win,
  input  rgbkf_pkg::win_ctl_t              ctl,
  input  logic                             out_ready,
  output logic                             out_valid,
  output rgbkf_pkg::out_item_t             out_data,
  output logic                             out_free
);

  function automatic logic [7:0] sat_byte(input logic signed [13:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // p[col][row]
  function automatic logic [7:0] kern_apply(input logic [2:0][2:0][7:0] p,
                                            input logic [rgbkf_pkg::MODE_W-1:0] mode);
    logic [9:0]         s_cor;
    logic [9:0]         s_edge;
    logic [11:0]        s_all;
    logic [12:0]        s_gau;
    logic [24:0]        box_prod;
    logic [11:0]        nine_c;
    logic [10:0]        five_c;
    logic [10:0]        emb_pos;
    logic [9:0]         emb_neg;
    logic [7:0]         r;
    s_cor    = 10'(p[0][0]) + 10'(p[2][0]) + 10'(p[0][2]) + 10'(p[2][2]);
    s_edge   = 10'(p[1][0]) + 10'(p[0][1]) + 10'(p[2][1]) + 10'(p[1][2]);
    s_all    = 12'(s_cor) + 12'(s_edge) + 12'(p[1][1]);
    s_gau    = 13'(s_cor) + {2'b00, s_edge, 1'b0} + {3'b000, p[1][1], 2'b00} + 13'd8;
    box_prod = 25'(s_all + 12'd4) * 25'(rgbkf_pkg::BOX_RECIP);
    nine_c   = {1'b0, p[1][1], 3'b000} + 12'(p[1][1]);
    five_c   = {1'b0, p[1][1], 2'b00} + 11'(p[1][1]);
    emb_pos  = 11'(p[1][1]) + 11'(p[2][1]) + 11'(p[1][2]) + {2'b00, p[2][2], 1'b0};
    emb_neg  = {1'b0, p[0][0], 1'b0} + 10'(p[1][0]) + 10'(p[0][1]);
    case (mode)
      rgbkf_pkg::MODE_GAUSS: begin
        r = s_gau[11:4];
      end
      rgbkf_pkg::MODE_OUTLINE: begin
        r = sat_byte($signed({2'b00, nine_c}) - $signed({2'b00, s_all}));
      end
      rgbkf_pkg::MODE_EMBOSS: begin
        r = sat_byte($signed({3'b000, emb_pos}) - $signed({4'b0000, emb_neg}));
      end
      rgbkf_pkg::MODE_SHARPEN: begin
        r = sat_byte($signed({3'b000, five_c}) - $signed({4'b0000, s_edge}));
      end
      default: begin
        r = box_prod[rgbkf_pkg::BOX_SHIFT+7:rgbkf_pkg::BOX_SHIFT];
      end
    endcase
    return r;
  endfunction

  logic [rgbkf_pkg::MODE_W-1:0] mode_r;
  logic                         out_v_r;
  rgbkf_pkg::out_item_t         out_data_r, res_nxt;
  logic [2:0][2:0][7:0]         pr, pg, pb;
  logic [2:0]                   col_ok, row_ok;

  always_comb begin
    col_ok = {ctl.right_ok, 1'b1, ctl.left_ok};
    row_ok = {ctl.down_ok, 1'b1, ctl.up_ok};
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        pr[c][r] = (col_ok[c] && row_ok[r]) ? win[c][r].red   : 8'd0;
        pg[c][r] = (col_ok[c] && row_ok[r]) ? win[c][r].green : 8'd0;
        pb[c][r] = (col_ok[c] && row_ok[r]) ? win[c][r].blue  : 8'd0;
      end
    end
    res_nxt.out_red   = kern_apply(pr, mode_r);
    res_nxt.out_green = kern_apply(pg, mode_r);
    res_nxt.out_blue  = kern_apply(pb, mode_r);
    res_nxt.frame_end = ctl.last;
  end

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rgbkf_pkg::MODE_BOX;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == rgbkf_pkg::REG_KERNEL_MODE)) begin
        mode_r <= cfg_data[rgbkf_pkg::MODE_W-1:0];
      end
      if (out_free) begin
        out_v_r <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule
